[sv/ssc_pkg.sv]
// shared constants and codes for the scissor stack clip unit
package ssc_pkg;

   localparam int SSC_STACK_DEPTH = 16;
   localparam int SSC_COORD_WIDTH = 16;

   localparam int MODE_WIDTH   = 2;
   localparam int IN_WIDTH     = 16;
   localparam int OUT_WIDTH    = 18;
   localparam int STATUS_WIDTH = 2;

   localparam int signed OUT_MAX = 131071;
   localparam int signed OUT_MIN = -131072;

   // value that x, y, w and h of a rectangle take when it misses the one below
   localparam int signed MISS_COORD = 5;

   typedef enum logic [MODE_WIDTH-1:0] {
      MODE_PUSH  = 2'd0,
      MODE_POP   = 2'd1,
      MODE_QUERY = 2'd2
   } mode_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_UNDERFLOW = 2'd2
   } status_type;

endpackage

[sv/ssc_if.sv]
// request and response channel interfaces of the scissor stack clip unit
interface ssc_req_if;
   import ssc_pkg::*;

   logic                        valid;
   logic                        ready;
   logic [MODE_WIDTH-1:0]       mode;
   logic signed [IN_WIDTH-1:0]  rect_x;
   logic signed [IN_WIDTH-1:0]  rect_y;
   logic signed [IN_WIDTH-1:0]  rect_w;
   logic signed [IN_WIDTH-1:0]  rect_h;

   modport source (output valid, mode, rect_x, rect_y, rect_w, rect_h, input ready);
   modport sink   (input valid, mode, rect_x, rect_y, rect_w, rect_h, output ready);
endinterface

interface ssc_rsp_if;
   import ssc_pkg::*;

   logic                        valid;
   logic                        ready;
   logic signed [OUT_WIDTH-1:0] clip_x;
   logic signed [OUT_WIDTH-1:0] clip_y;
   logic signed [OUT_WIDTH-1:0] clip_w;
   logic signed [OUT_WIDTH-1:0] clip_h;
   logic [STATUS_WIDTH-1:0]     status;

   modport source (output valid, clip_x, clip_y, clip_w, clip_h, status, input ready);
   modport sink   (input valid, clip_x, clip_y, clip_w, clip_h, status, output ready);
endinterface

[sv/scissor_stack_clip_unit.sv]
// scissor rectangle stack with clipping of the top entry against the one below
//
//  channel  | dir | handshake    | payload
//  req_ch   | in  | valid/ready  | mode, rect_x, rect_y, rect_w, rect_h
//  rsp_ch   | out | valid/ready  | clip_x, clip_y, clip_w, clip_h, status
//
// one beat per cycle unless rsp_ch stalls: each request is answered next cycle.
// the top two entries live in registers; deeper entries sit in a memory whose
// registered read port always holds the third entry, so a pop needs no wait.
// reset empties the stack to the base entry at once, no clearing pass.
// req_ch.ready is low only while a response waits on a stalled rsp_ch.
module scissor_stack_clip_unit #(
   parameter int STACK_DEPTH = ssc_pkg::SSC_STACK_DEPTH,
   parameter int COORD_WIDTH = ssc_pkg::SSC_COORD_WIDTH
) (
   input  logic          clock,
   input  logic          reset,
   ssc_req_if.sink       req_ch,
   ssc_rsp_if.source     rsp_ch
);
   import ssc_pkg::*;

   localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W = $clog2(STACK_DEPTH);
   localparam int WW     = COORD_WIDTH + 3;
   localparam int SW     = (WW > OUT_WIDTH) ? WW : OUT_WIDTH;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] x;
      logic signed [COORD_WIDTH-1:0] y;
      logic signed [COORD_WIDTH-1:0] w;
      logic signed [COORD_WIDTH-1:0] h;
   } rect_type;

   function automatic logic signed [OUT_WIDTH-1:0] saturate(input logic signed [WW-1:0] v);
      logic signed [SW-1:0] e;
      e = SW'(v);
      if (e > SW'(OUT_MAX)) e = SW'(OUT_MAX);
      if (e < SW'(OUT_MIN)) e = SW'(OUT_MIN);
      return signed'(e[OUT_WIDTH-1:0]);
   endfunction

   rect_type              mem [STACK_DEPTH];
   rect_type              top_ff, top_in;
   rect_type              below_ff, below_in;
   rect_type              deep_ff;
   logic [CNT_W-1:0]      count_ff, count_in;

   logic                  rsp_valid_ff;
   logic signed [OUT_WIDTH-1:0] rsp_x_ff, rsp_y_ff, rsp_w_ff, rsp_h_ff;
   logic [STATUS_WIDTH-1:0]     rsp_status_ff;

   logic                  accept;
   logic                  push_ok, pop_ok;
   logic                  wr_en;
   logic [ADDR_W-1:0]     wr_addr, rd_addr;
   logic [CNT_W-1:0]      rd_count;
   rect_type              new_rect;
   logic [31:0]           ext_x, ext_y, ext_w, ext_h;
   rect_type              clip_t, clip_b;
   logic                  has_below;
   logic [STATUS_WIDTH-1:0] status;

   logic signed [WW-1:0]  tx, ty, tw, th, bx, by, bw, bh, bfx, bfy;

   assign accept    = req_ch.valid && req_ch.ready;
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;

   // pushed coordinates wrap to the stored width
   assign ext_x = 32'(req_ch.rect_x);
   assign ext_y = 32'(req_ch.rect_y);
   assign ext_w = 32'(req_ch.rect_w);
   assign ext_h = 32'(req_ch.rect_h);
   assign new_rect.x = signed'(ext_x[COORD_WIDTH-1:0]);
   assign new_rect.y = signed'(ext_y[COORD_WIDTH-1:0]);
   assign new_rect.w = signed'(ext_w[COORD_WIDTH-1:0]);
   assign new_rect.h = signed'(ext_h[COORD_WIDTH-1:0]);

   assign push_ok = (req_ch.mode == MODE_PUSH) && (count_ff != CNT_W'(STACK_DEPTH));
   assign pop_ok  = (req_ch.mode == MODE_POP) && (count_ff != CNT_W'(1));

   always_comb begin
      top_in   = top_ff;
      below_in = below_ff;
      count_in = count_ff;
      wr_en    = 1'b0;
      if (accept && push_ok) begin
         top_in   = new_rect;
         below_in = top_ff;
         count_in = count_ff + CNT_W'(1);
         // the old second entry, the base included, spills into the memory
         wr_en    = (count_ff >= CNT_W'(2));
      end else if (accept && pop_ok) begin
         top_in   = below_ff;
         below_in = deep_ff;
         count_in = count_ff - CNT_W'(1);
      end
   end

   assign wr_addr  = ADDR_W'(count_ff - CNT_W'(2));
   assign rd_count = count_in - CNT_W'(3);
   assign rd_addr  = rd_count[ADDR_W-1:0];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= below_ff;
      // a push writes exactly the entry that becomes third from the top
      if (wr_en && (wr_addr == rd_addr)) deep_ff <= below_ff;
      else                               deep_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= CNT_W'(1);
         top_ff   <= '1;
      end else begin
         count_ff <= count_in;
         top_ff   <= top_in;
      end
      below_ff <= below_in;
   end

   // pick the pair to clip: a successful push shows the new top
   always_comb begin
      if (push_ok) begin
         clip_t    = new_rect;
         clip_b    = top_ff;
         has_below = 1'b1;
      end else begin
         clip_t    = top_ff;
         clip_b    = below_ff;
         has_below = (count_ff != CNT_W'(1));
      end
   end

   always_comb begin
      tx  = WW'(clip_t.x);
      ty  = WW'(clip_t.y);
      tw  = WW'(clip_t.w);
      th  = WW'(clip_t.h);
      bx  = WW'(clip_b.x);
      by  = WW'(clip_b.y);
      bw  = WW'(clip_b.w);
      bh  = WW'(clip_b.h);
      bfx = bx + bw;
      bfy = by + bh;
      if (has_below && !(clip_b.x[COORD_WIDTH-1] && clip_b.y[COORD_WIDTH-1] &&
                         clip_b.w[COORD_WIDTH-1] && clip_b.h[COORD_WIDTH-1])) begin
         if (tx < bx) begin
            tw = tw - (bx - tx);
            tx = bx;
         end
         if (tx + tw > bfx) tw = bfx - tx;
         if (ty < by) begin
            th = th - (by - ty);
            ty = by;
         end
         if (ty + th > bfy) th = bfy - ty;
         if (tx > bfx || ty > bfy) begin
            tx = WW'(MISS_COORD);
            ty = WW'(MISS_COORD);
            tw = WW'(MISS_COORD);
            th = WW'(MISS_COORD);
         end
      end
   end

   always_comb begin
      status = STATUS_OK;
      if (req_ch.mode == MODE_PUSH && !push_ok) status = STATUS_FULL;
      if (req_ch.mode == MODE_POP && !pop_ok)   status = STATUS_UNDERFLOW;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (accept) begin
         rsp_x_ff      <= saturate(tx);
         rsp_y_ff      <= saturate(ty);
         rsp_w_ff      <= saturate(tw);
         rsp_h_ff      <= saturate(th);
         rsp_status_ff <= status;
      end
   end

   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.clip_x = rsp_x_ff;
   assign rsp_ch.clip_y = rsp_y_ff;
   assign rsp_ch.clip_w = rsp_w_ff;
   assign rsp_ch.clip_h = rsp_h_ff;
   assign rsp_ch.status = rsp_status_ff;

endmodule

[sv/ssc_checker.sv]
// port checks for the scissor stack clip unit and their bind
module ssc_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_ready,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic signed [ssc_pkg::OUT_WIDTH-1:0]  rsp_clip_x,
   input logic signed [ssc_pkg::OUT_WIDTH-1:0]  rsp_clip_y,
   input logic signed [ssc_pkg::OUT_WIDTH-1:0]  rsp_clip_w,
   input logic signed [ssc_pkg::OUT_WIDTH-1:0]  rsp_clip_h,
   input logic [ssc_pkg::STATUS_WIDTH-1:0]      rsp_status
);
   import ssc_pkg::*;

   // a stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_clip_x) && $stable(rsp_clip_y)
         && $stable(rsp_clip_w) && $stable(rsp_clip_h) && $stable(rsp_status))
      else $error("response changed while stalled");

   // every accepted request is answered in the next cycle
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("no response after accepted request");

   // a response only appears after a request beat
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready))
      else $error("response without request");

   // an empty output register never blocks requests
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request blocked with no pending response");

   // a refused pop sits on the base entry, which reads as no scissor
   a_underflow_base: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_UNDERFLOW |->
         rsp_clip_x == '1 && rsp_clip_y == '1 && rsp_clip_w == '1 && rsp_clip_h == '1)
      else $error("underflow response is not the base entry");

endmodule

bind scissor_stack_clip_unit ssc_checker u_ssc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_ch.valid),
   .req_ready  (req_ch.ready),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .rsp_clip_x (rsp_ch.clip_x),
   .rsp_clip_y (rsp_ch.clip_y),
   .rsp_clip_w (rsp_ch.clip_w),
   .rsp_clip_h (rsp_ch.clip_h),
   .rsp_status (rsp_ch.status)
);

[test/ssc_clip_checker.sv]
// checker for the scissor stack clip unit: predicts every response and compares it
`timescale 1ns / 1ps

module ssc_clip_checker (
   input  logic clock,
   input  logic reset,
   ssc_req_if   req_mon,
   ssc_rsp_if   rsp_mon,
   output int   fail_count,
   output int   expected_left,
   output int   checked_count
);
   import ssc_pkg::*;

   typedef struct {
      longint x;
      longint y;
      longint w;
      longint h;
   } rect_type;

   typedef struct {
      logic signed [OUT_WIDTH-1:0] x;
      logic signed [OUT_WIDTH-1:0] y;
      logic signed [OUT_WIDTH-1:0] w;
      logic signed [OUT_WIDTH-1:0] h;
      status_type                  status;
   } clip_beat_type;

   rect_type      scissor_stack [SSC_STACK_DEPTH];
   int            stack_fill;
   clip_beat_type clip_queue [$];
   clip_beat_type want;
   int            fails = 0;
   int            checks = 0;

   function automatic longint wrap_coord(logic signed [IN_WIDTH-1:0] v);
      longint wide;
      wide = longint'(v);
      wide = wide <<< (64 - SSC_COORD_WIDTH);
      return wide >>> (64 - SSC_COORD_WIDTH);
   endfunction

   function automatic logic signed [OUT_WIDTH-1:0] saturate_out(longint v);
      if (v > OUT_MAX)
         return OUT_WIDTH'(OUT_MAX);
      if (v < OUT_MIN)
         return OUT_WIDTH'(OUT_MIN);
      return v[OUT_WIDTH-1:0];
   endfunction

   function automatic rect_type clip_to_below(rect_type top, rect_type below);
      longint x_far;
      longint y_far;
      x_far = below.x + below.w;
      y_far = below.y + below.h;
      // trim left and top edges by moving the origin in
      if (top.x < below.x) begin
         top.w = top.w - (below.x - top.x);
         top.x = below.x;
      end
      if (top.x + top.w > x_far)
         top.w = x_far - top.x;
      if (top.y < below.y) begin
         top.h = top.h - (below.y - top.y);
         top.y = below.y;
      end
      if (top.y + top.h > y_far)
         top.h = y_far - top.y;
      // starts past the far edge of the one below
      if (top.x > x_far || top.y > y_far)
         top = '{longint'(MISS_COORD), longint'(MISS_COORD),
                 longint'(MISS_COORD), longint'(MISS_COORD)};
      return top;
   endfunction

   function automatic rect_type effective_top();
      rect_type top;
      rect_type below;
      top = scissor_stack[stack_fill - 1];
      if (stack_fill < 2)
         return top;
      below = scissor_stack[stack_fill - 2];
      if (below.x < 0 && below.y < 0 && below.w < 0 && below.h < 0)
         return top;
      return clip_to_below(top, below);
   endfunction

   function automatic clip_beat_type apply_request(logic [MODE_WIDTH-1:0] mode,
                                                   logic signed [IN_WIDTH-1:0] x,
                                                   logic signed [IN_WIDTH-1:0] y,
                                                   logic signed [IN_WIDTH-1:0] w,
                                                   logic signed [IN_WIDTH-1:0] h);
      clip_beat_type beat;
      rect_type      r;
      beat.status = STATUS_OK;
      if (mode == MODE_PUSH) begin
         if (stack_fill >= SSC_STACK_DEPTH) begin
            beat.status = STATUS_FULL;
         end else begin
            scissor_stack[stack_fill] = '{wrap_coord(x), wrap_coord(y),
                                          wrap_coord(w), wrap_coord(h)};
            stack_fill++;
         end
         r = effective_top();
      end else if (mode == MODE_POP) begin
         // pop answers with the top as it stood before the pop
         r = effective_top();
         if (stack_fill <= 1)
            beat.status = STATUS_UNDERFLOW;
         else
            stack_fill--;
      end else begin
         r = effective_top();
      end
      beat.x = saturate_out(r.x);
      beat.y = saturate_out(r.y);
      beat.w = saturate_out(r.w);
      beat.h = saturate_out(r.h);
      return beat;
   endfunction

   task automatic check_field(string name, longint expected_val, longint actual_val);
      if (expected_val != actual_val) begin
         $error("%s mismatch: expected %0d, got %0d", name, expected_val, actual_val);
         fails++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         foreach (scissor_stack[i])
            scissor_stack[i] = '{0, 0, 0, 0};
         scissor_stack[0] = '{-1, -1, -1, -1};
         stack_fill = 1;
         clip_queue.delete();
      end else begin
         // a response always trails its request, so compare before queuing
         if (rsp_mon.valid && rsp_mon.ready) begin
            checks++;
            if (clip_queue.size() == 0) begin
               $error("response beat with no request outstanding");
               fails++;
            end else begin
               want = clip_queue.pop_front();
               check_field("clip_x", longint'(want.x), longint'(rsp_mon.clip_x));
               check_field("clip_y", longint'(want.y), longint'(rsp_mon.clip_y));
               check_field("clip_w", longint'(want.w), longint'(rsp_mon.clip_w));
               check_field("clip_h", longint'(want.h), longint'(rsp_mon.clip_h));
               check_field("status", longint'(want.status), longint'(rsp_mon.status));
            end
         end
         if (req_mon.valid && req_mon.ready)
            clip_queue = {clip_queue,
                          apply_request(req_mon.mode, req_mon.rect_x, req_mon.rect_y,
                                        req_mon.rect_w, req_mon.rect_h)};
      end
      fail_count    <= fails;
      expected_left <= clip_queue.size();
      checked_count <= checks;
   end

endmodule

[test/testbench.sv]
// top of the scissor stack clip unit testbench: stimulus, handshake idling and verdict
`timescale 1ns / 1ps

module testbench;
   import ssc_pkg::*;

   localparam logic [MODE_WIDTH-1:0] MODE_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS = 1850;
   localparam int STALL_LIMIT  = 4000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   int send_idle_pct = 36;
   int recv_idle_pct = 68;
   int stall_cycles  = 0;
   int push_count    = 0;
   int pop_count     = 0;
   int query_count   = 0;
   int unused_count  = 0;
   int fail_count;
   int expected_left;
   int checked_count;

   ssc_req_if req_ch ();
   ssc_rsp_if rsp_ch ();

   scissor_stack_clip_unit u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   ssc_clip_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_ch),
      .rsp_mon       (rsp_ch),
      .fail_count    (fail_count),
      .expected_left (expected_left),
      .checked_count (checked_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver stalls at random, rate set per phase
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // watchdog on cycles with no beat moving on either channel
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            stall_cycles <= 0;
         end else if (stall_cycles >= STALL_LIMIT) begin
            $error("no beat moved for %0d cycles", STALL_LIMIT);
            $display("CHECKS FAILED");
            $finish;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
      end
   end

   function automatic logic signed [IN_WIDTH-1:0] pick_coord(int style);
      if (style <= 5)
         return IN_WIDTH'($urandom_range(0, 400));
      if (style == 6)
         return IN_WIDTH'(-1);
      if (style == 7)
         return IN_WIDTH'($urandom());
      if (style == 8)
         return IN_WIDTH'(int'($urandom_range(0, 400)) - 200);
      case ($urandom_range(0, 3))
         0: return 32767;
         1: return -32768;
         2: return 0;
         default: return -1;
      endcase
   endfunction

   task automatic send_item(input logic [MODE_WIDTH-1:0] mode,
                            input logic signed [IN_WIDTH-1:0] x,
                            input logic signed [IN_WIDTH-1:0] y,
                            input logic signed [IN_WIDTH-1:0] w,
                            input logic signed [IN_WIDTH-1:0] h);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.mode   <= mode;
      req_ch.rect_x <= x;
      req_ch.rect_y <= y;
      req_ch.rect_w <= w;
      req_ch.rect_h <= h;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
      if (mode == MODE_PUSH)
         push_count++;
      else if (mode == MODE_POP)
         pop_count++;
      else if (mode == MODE_QUERY)
         query_count++;
      else
         unused_count++;
   endtask

   task automatic send_random(input logic [MODE_WIDTH-1:0] mode);
      int style;
      style = $urandom_range(0, 9);
      send_item(mode, pick_coord(style), pick_coord(style), pick_coord(style),
                pick_coord(style));
   endtask

   // hold the request side until every outstanding response has come back
   task automatic drain();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (expected_left != 0)
         @(negedge clock);
   endtask

   // alternating push-heavy and pop-heavy runs walk the stack between base and full
   task automatic run_random(input int count);
      int                    left;
      int                    run_len;
      int                    pick;
      bit                    grow;
      logic [MODE_WIDTH-1:0] mode;
      left = count;
      grow = 1'b1;
      while (left > 0) begin
         run_len = $urandom_range(6, 30);
         while (run_len > 0 && left > 0) begin
            pick = $urandom_range(0, 99);
            if (pick < 5)
               mode = MODE_UNUSED;
            else if (pick < 20)
               mode = MODE_QUERY;
            else if (pick < 80)
               mode = grow ? MODE_PUSH : MODE_POP;
            else
               mode = grow ? MODE_POP : MODE_PUSH;
            send_random(mode);
            if ($urandom_range(0, 299) == 0)
               drain();
            run_len--;
            left--;
         end
         grow = !grow;
      end
   endtask

   initial begin
      req_ch.valid  = 1'b0;
      req_ch.mode   = MODE_QUERY;
      req_ch.rect_x = '0;
      req_ch.rect_y = '0;
      req_ch.rect_w = '0;
      req_ch.rect_h = '0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      send_item(MODE_QUERY, 0, 0, 0, 0);
      send_item(MODE_POP, 0, 0, 0, 0);             // pop at base is refused
      send_item(MODE_UNUSED, 1, 2, 3, 4);
      send_item(MODE_PUSH, 100, 100, 200, 150);    // below is the no-scissor base
      send_item(MODE_PUSH, 50, 60, 100, 100);      // left and top edges trimmed
      send_item(MODE_POP, 0, 0, 0, 0);
      send_item(MODE_PUSH, 250, 200, 200, 200);    // right and bottom overhang cut
      send_item(MODE_POP, 0, 0, 0, 0);
      send_item(MODE_PUSH, 301, 120, 10, 10);      // starts past the right edge
      send_item(MODE_POP, 0, 0, 0, 0);
      send_item(MODE_PUSH, 32767, 32767, 32767, 32767);
      send_item(MODE_PUSH, -32768, -32768, -32768, -32768);
      // fill to the top, last push is refused
      repeat (SSC_STACK_DEPTH - 4 + 1)
         send_random(MODE_PUSH);

      run_random(RANDOM_ITEMS / 3);
      drain();
      send_idle_pct = 68;
      recv_idle_pct = 36;
      run_random(RANDOM_ITEMS / 3);
      drain();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
      drain();
      repeat (8) @(posedge clock);

      $display("run covered %0d requests: %0d push, %0d pop, %0d query, %0d unused mode",
               push_count + pop_count + query_count + unused_count,
               push_count, pop_count, query_count, unused_count);
      $display("%0d response beats compared under three sender/receiver stall mixes",
               checked_count);
      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
